>>> src/tsp_pkg.sv
// Shared types, codes and defaults for the two-stream timestamp pairer.
`default_nettype none
package tsp_pkg;

  localparam int DEF_QUEUE_DEPTH = 8;

  localparam logic [1:0] ACT_PUSH = 2'd0;
  localparam logic [1:0] ACT_POP  = 2'd1;
  localparam logic [1:0] ACT_TICK = 2'd2;

  localparam logic [2:0] KIND_PUSH_OK   = 3'd0;
  localparam logic [2:0] KIND_PUSH_DROP = 3'd1;
  localparam logic [2:0] KIND_POP_NONE  = 3'd2;
  localparam logic [2:0] KIND_PAIRED    = 3'd3;
  localparam logic [2:0] KIND_SINGLE    = 3'd4;

  localparam logic [1:0] REG_TOLERANCE = 2'd0;
  localparam logic [1:0] REG_HOLD      = 2'd1;
  localparam logic [1:0] REG_LIMIT     = 2'd2;

  localparam logic [63:0] RST_TOLERANCE = 64'd5000000;
  localparam logic [31:0] RST_HOLD      = 32'd100;
  localparam logic [3:0]  RST_LIMIT     = 4'd8;

  typedef struct packed {
    logic [63:0] timestamp;
    logic [63:0] host_recv;
    logic [31:0] frame_ident;
    logic [31:0] frame_bytes;
    logic [31:0] arrival_tick;
  } entry_t;

  typedef struct packed {
    logic push;
    logic drop;
  } q_op_t;

endpackage
`default_nettype wire

>>> src/tsp_cell.sv
// One queue cell: holds a descriptor, shifts toward the head or loads a new one.
`default_nettype none
module tsp_cell (
  input  wire             clk,
  input  wire             shift,
  input  wire             load,
  input  tsp_pkg::entry_t din,
  input  tsp_pkg::entry_t nb,
  output tsp_pkg::entry_t q
);
  import tsp_pkg::*;

  entry_t q_r;

  always_ff @(posedge clk) begin
    if (load) begin
      q_r <= din;
    end else if (shift) begin
      q_r <= nb;
    end
  end

  assign q = q_r;
endmodule
`default_nettype wire

>>> src/tsp_queue.sv
// Per-stream descriptor queue built as a shifting chain of cells, head at cell 0.
`default_nettype none
module tsp_queue #(
  parameter int QUEUE_DEPTH = tsp_pkg::DEF_QUEUE_DEPTH,
  parameter int CW = $clog2(QUEUE_DEPTH + 1)
) (
  input  wire             clk,
  input  wire             rst_n,
  input  tsp_pkg::q_op_t  op,
  input  tsp_pkg::entry_t din,
  output tsp_pkg::entry_t head,
  output logic [CW-1:0]   count
);
  import tsp_pkg::*;

  logic [CW-1:0] cnt_r, cnt_nxt, wpos;
  entry_t        cq [QUEUE_DEPTH];

  assign wpos    = op.drop ? cnt_r - CW'(1) : cnt_r;
  assign cnt_nxt = cnt_r + CW'(op.push) - CW'(op.drop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    entry_t nb_w;
    if (i == QUEUE_DEPTH - 1) begin : g_end
      assign nb_w = cq[i];
    end else begin : g_mid
      assign nb_w = cq[i+1];
    end
    tsp_cell u_cell (
      .clk   (clk),
      .shift (op.drop),
      .load  (op.push && (wpos == CW'(i))),
      .din   (din),
      .nb    (nb_w),
      .q     (cq[i])
    );
  end

  assign head  = cq[0];
  assign count = cnt_r;
endmodule
`default_nettype wire

>>> src/two_stream_timestamp_pairer.sv
// Top level: two timestamp queues, pop decision sequencer and result register.
// Push: accepted in IDLE, then the result is loaded in the PUSH state once the output is free.
// Pop: accepted in IDLE, then runs the difference (DIFF), magnitude (ABS) and decision
// (EMIT) states; the first result loads in EMIT, and a pair loads its second result in EMIT2.
// Tick: counted on acceptance, no result. One item in flight; a result not yet taken stalls the sequencer.
// Synchronous active-low reset clears counters and fill counts and loads config defaults.
`default_nettype none
module two_stream_timestamp_pairer #(
  parameter int QUEUE_DEPTH = tsp_pkg::DEF_QUEUE_DEPTH
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_valid,
  output logic        in_ready,
  input  wire  [1:0]  in_action,
  input  wire         in_stream,
  input  wire  [63:0] in_timestamp,
  input  wire  [63:0] in_host_recv,
  input  wire  [31:0] in_frame_ident,
  input  wire  [31:0] in_frame_bytes,
  output logic        out_valid,
  input  wire         out_ready,
  output logic [2:0]  out_kind,
  output logic        out_side,
  output logic [31:0] out_pair_id,
  output logic signed [63:0] out_skew,
  output logic [63:0] out_timestamp,
  output logic [63:0] out_host_recv,
  output logic [31:0] out_frame_ident,
  output logic [31:0] out_frame_bytes,
  output logic        out_last,
  input  wire         cfg_we,
  input  wire  [1:0]  cfg_index,
  input  wire  [63:0] cfg_data
);
  import tsp_pkg::*;

  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int LW = (CW > 4) ? CW : 4;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_PUSH  = 3'd1;
  localparam logic [2:0] ST_DIFF  = 3'd2;
  localparam logic [2:0] ST_ABS   = 3'd3;
  localparam logic [2:0] ST_EMIT  = 3'd4;
  localparam logic [2:0] ST_EMIT2 = 3'd5;

  logic [2:0]  state_r, state_nxt;
  logic [63:0] tol_r;
  logic [31:0] hold_r;
  logic [3:0]  limit_r;
  logic [31:0] tick_r, emit_r;

  entry_t      ent_r;
  logic        strm_r;
  logic [63:0] diff_r, dist_r, skew_r;
  logic [31:0] el0_r, el1_r;
  logic        hok0_r, hok1_r;

  q_op_t       op0, op1;
  entry_t      head0, head1;
  logic [CW-1:0] cnt0, cnt1;

  logic        out_valid_r;
  logic [2:0]  kind_r;
  logic        side_r, last_r;
  logic [31:0] pid_r, fid_r, fb_r;
  logic [63:0] oskew_r, ots_r, ohr_r;

  logic        ld;
  logic [2:0]  ld_kind;
  logic        ld_side, ld_last, ld_have, ld_cnt;
  logic [63:0] ld_skew;
  entry_t      ld_ent;

  logic        out_free, acc, nz0, nz1, full;
  logic [LW-1:0] lim_ext, eff_lim, cnt_sel;

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == ST_IDLE);
  assign acc      = in_valid && in_ready;
  assign nz0      = (cnt0 != '0);
  assign nz1      = (cnt1 != '0);

  assign lim_ext  = LW'(limit_r);
  assign eff_lim  = (lim_ext == '0) ? LW'(1) :
                    (lim_ext > LW'(QUEUE_DEPTH)) ? LW'(QUEUE_DEPTH) : lim_ext;
  assign cnt_sel  = strm_r ? LW'(cnt1) : LW'(cnt0);
  assign full     = (cnt_sel >= eff_lim);

  tsp_queue #(.QUEUE_DEPTH(QUEUE_DEPTH), .CW(CW)) u_q0 (
    .clk(clk), .rst_n(rst_n), .op(op0), .din(ent_r), .head(head0), .count(cnt0)
  );
  tsp_queue #(.QUEUE_DEPTH(QUEUE_DEPTH), .CW(CW)) u_q1 (
    .clk(clk), .rst_n(rst_n), .op(op1), .din(ent_r), .head(head1), .count(cnt1)
  );

  always_comb begin
    state_nxt = state_r;
    op0       = '0;
    op1       = '0;
    ld        = 1'b0;
    ld_kind   = KIND_POP_NONE;
    ld_side   = 1'b0;
    ld_last   = 1'b1;
    ld_have   = 1'b0;
    ld_cnt    = 1'b0;
    ld_skew   = '0;
    ld_ent    = head0;
    unique case (state_r)
      ST_IDLE: begin
        if (acc) begin
          if (in_action == ACT_PUSH) begin
            state_nxt = ST_PUSH;
          end else if (in_action == ACT_POP) begin
            state_nxt = ST_DIFF;
          end
        end
      end
      ST_PUSH: begin
        if (out_free) begin
          ld        = 1'b1;
          ld_kind   = full ? KIND_PUSH_DROP : KIND_PUSH_OK;
          ld_side   = strm_r;
          op0.push  = !strm_r;
          op0.drop  = !strm_r && full;
          op1.push  = strm_r;
          op1.drop  = strm_r && full;
          state_nxt = ST_IDLE;
        end
      end
      ST_DIFF: state_nxt = ST_ABS;
      ST_ABS:  state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (out_free) begin
          ld        = 1'b1;
          state_nxt = ST_IDLE;
          if (nz0 && nz1) begin
            ld_have = 1'b1;
            if (dist_r <= tol_r) begin
              ld_kind   = KIND_PAIRED;
              ld_skew   = skew_r;
              ld_last   = 1'b0;
              state_nxt = ST_EMIT2;
            end else begin
              ld_kind  = KIND_SINGLE;
              ld_cnt   = 1'b1;
              ld_side  = !diff_r[63];
              ld_ent   = diff_r[63] ? head0 : head1;
              op0.drop = diff_r[63];
              op1.drop = !diff_r[63];
            end
          end else if (nz0 && hok0_r) begin
            ld_have  = 1'b1;
            ld_kind  = KIND_SINGLE;
            ld_cnt   = 1'b1;
            op0.drop = 1'b1;
          end else if (nz1 && hok1_r) begin
            ld_have  = 1'b1;
            ld_kind  = KIND_SINGLE;
            ld_cnt   = 1'b1;
            ld_side  = 1'b1;
            ld_ent   = head1;
            op1.drop = 1'b1;
          end
        end
      end
      ST_EMIT2: begin
        if (out_free) begin
          ld        = 1'b1;
          ld_have   = 1'b1;
          ld_kind   = KIND_PAIRED;
          ld_skew   = skew_r;
          ld_side   = 1'b1;
          ld_ent    = head1;
          ld_cnt    = 1'b1;
          op0.drop  = 1'b1;
          op1.drop  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      tol_r       <= RST_TOLERANCE;
      hold_r      <= RST_HOLD;
      limit_r     <= RST_LIMIT;
      tick_r      <= '0;
      emit_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_TOLERANCE: tol_r   <= cfg_data;
          REG_HOLD:      hold_r  <= cfg_data[31:0];
          REG_LIMIT:     limit_r <= cfg_data[3:0];
          default: ;
        endcase
      end
      if (acc && in_action == ACT_TICK) begin
        tick_r <= tick_r + 32'd1;
      end
      if (ld && ld_cnt) begin
        emit_r <= emit_r + 32'd1;
      end
      if (ld) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      strm_r             <= in_stream;
      ent_r.timestamp    <= in_timestamp;
      ent_r.host_recv    <= in_host_recv;
      ent_r.frame_ident  <= in_frame_ident;
      ent_r.frame_bytes  <= in_frame_bytes;
      ent_r.arrival_tick <= tick_r;
    end
    if (state_r == ST_DIFF) begin
      diff_r <= head0.timestamp - head1.timestamp;
      el0_r  <= tick_r - head0.arrival_tick;
      el1_r  <= tick_r - head1.arrival_tick;
    end
    if (state_r == ST_ABS) begin
      skew_r <= 64'd0 - diff_r;
      dist_r <= diff_r[63] ? 64'd0 - diff_r : diff_r;
      hok0_r <= (el0_r >= hold_r);
      hok1_r <= (el1_r >= hold_r);
    end
    if (ld) begin
      kind_r  <= ld_kind;
      side_r  <= ld_side;
      last_r  <= ld_last;
      pid_r   <= ld_have ? emit_r : 32'd0;
      oskew_r <= ld_skew;
      ots_r   <= ld_have ? ld_ent.timestamp : 64'd0;
      ohr_r   <= ld_have ? ld_ent.host_recv : 64'd0;
      fid_r   <= ld_have ? ld_ent.frame_ident : 32'd0;
      fb_r    <= ld_have ? ld_ent.frame_bytes : 32'd0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_kind        = kind_r;
  assign out_side        = side_r;
  assign out_pair_id     = pid_r;
  assign out_skew        = oskew_r;
  assign out_timestamp   = ots_r;
  assign out_host_recv   = ohr_r;
  assign out_frame_ident = fid_r;
  assign out_frame_bytes = fb_r;
  assign out_last        = last_r;

  a_pair_first_side0: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !last_r |-> kind_r == KIND_PAIRED && !side_r)
    else $error("first pair result not side 0");
  a_emit2_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_EMIT2 |-> nz0 && nz1)
    else $error("second pair result with an empty queue");
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt0 <= CW'(QUEUE_DEPTH) && cnt1 <= CW'(QUEUE_DEPTH))
    else $error("queue fill beyond depth");
  a_push_seq: assert property (@(posedge clk) disable iff (!rst_n)
    acc && in_action == ACT_PUSH |=> state_r == ST_PUSH)
    else $error("push request not sequenced");
endmodule
`default_nettype wire
